/* sv/interval_union_span_check_unit_assert.svh */
// Assertion macros used by the checker of the span check unit.
`ifndef INTERVAL_UNION_SPAN_CHECK_UNIT_ASSERT_SVH
`define INTERVAL_UNION_SPAN_CHECK_UNIT_ASSERT_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define IUS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("span check assertion failed");

// Concurrent assertion that is checked at every edge, reset included.
`define IUS_ASSERT_ANY(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("span check assertion failed");

`endif

/* sv/ius_pkg.sv */
package ius_pkg;

    // Default sizes of the store and of one coordinate.
    localparam int unsigned MAX_INTERVALS_DEF = 64;
    localparam int unsigned COORD_WIDTH_DEF   = 16;

    // Width of the union coordinates in a result word.
    localparam int unsigned RES_WIDTH = 16;

    // Depth of the queue between the front and the back.
    localparam int unsigned QUEUE_DEPTH = 2;

    // Classification that the front attaches to every word.
    typedef struct packed {
        logic keep;
        logic last;
    } t_item_ctl;

    // Sequencer states of the back.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_EV_RD,
        ST_EV_CMP,
        ST_OUT
    } t_back_state;

endpackage

/* sv/ius_channels.sv */
// Input channel: one interval per word.
interface ius_in_if #(
    parameter int unsigned CW = ius_pkg::COORD_WIDTH_DEF
);
    logic          valid;
    logic          ready;
    logic [CW-1:0] span_begin;
    logic [CW-1:0] span_finish;
    logic          final_item;

    modport source (output valid, span_begin, span_finish, final_item, input ready);
    modport sink   (input valid, span_begin, span_finish, final_item, output ready);
endinterface

// Output channel: one result word per set.
interface ius_out_if;
    import ius_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 connected;
    logic [RES_WIDTH-1:0] union_begin;
    logic [RES_WIDTH-1:0] union_finish;
    logic                 overflowed;

    modport source (output valid, connected, union_begin, union_finish, overflowed,
                    input ready);
    modport sink   (input valid, connected, union_begin, union_finish, overflowed,
                    output ready);
endinterface

/* sv/ius_front.sv */
module ius_front #(
    parameter int unsigned MAX_INTERVALS = ius_pkg::MAX_INTERVALS_DEF,
    parameter int unsigned COORD_WIDTH   = ius_pkg::COORD_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    ius_in_if.sink                 i_in,
    input  logic                   i_full,
    output logic                   o_push,
    output logic [COORD_WIDTH-1:0] o_begin,
    output logic [COORD_WIDTH-1:0] o_finish,
    output ius_pkg::t_item_ctl     o_ctl
);
    import ius_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_INTERVALS + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             w_acc;

    // A word is taken whenever the queue has room.
    assign i_in.ready = !i_full;
    assign w_acc      = i_in.valid && !i_full;

    // Classify: a word finds room in the store only while the set is below depth.
    assign o_push     = w_acc;
    assign o_begin    = i_in.span_begin;
    assign o_finish   = i_in.span_finish;
    assign o_ctl.keep = (r_cnt < CNT_W'(MAX_INTERVALS));
    assign o_ctl.last = i_in.final_item;

    // Count of kept words in the current set, cleared by the marked word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_acc) begin
            if (i_in.final_item) begin
                r_cnt <= '0;
            end else if (o_ctl.keep) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

endmodule

/* sv/ius_queue.sv */
module ius_queue #(
    parameter int unsigned WIDTH = 34,
    parameter int unsigned DEPTH = ius_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill level, wrapping at the depth.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

/* sv/ius_back.sv */
module ius_back #(
    parameter int unsigned MAX_INTERVALS = ius_pkg::MAX_INTERVALS_DEF,
    parameter int unsigned COORD_WIDTH   = ius_pkg::COORD_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_empty,
    output logic                   o_pop,
    input  logic [COORD_WIDTH-1:0] i_begin,
    input  logic [COORD_WIDTH-1:0] i_finish,
    input  ius_pkg::t_item_ctl     i_ctl,
    ius_out_if.source              o_out
);
    import ius_pkg::*;

    localparam int unsigned AW    = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_INTERVALS + 1);
    localparam int unsigned DW    = 2 * COORD_WIDTH;

    t_back_state r_state;
    t_back_state n_state;

    // Interval under insertion.
    logic [COORD_WIDTH-1:0] r_b;
    logic [COORD_WIDTH-1:0] r_f;
    logic                   r_last;

    // Store bookkeeping.
    logic [CNT_W-1:0]       r_cnt;
    logic [CNT_W-1:0]       r_pos;
    logic [CNT_W-1:0]       w_pos_m1;
    logic                   r_ovf;

    // Evaluation walk.
    logic [CNT_W-1:0]       r_idx;
    logic [COORD_WIDTH-1:0] r_lo;
    logic [COORD_WIDTH-1:0] r_hi;
    logic                   r_join;

    // Ordered store with one write and one registered read port.
    logic [DW-1:0]          r_mem [MAX_INTERVALS];
    logic [DW-1:0]          r_rd;
    logic [COORD_WIDTH-1:0] w_rd_begin;
    logic [COORD_WIDTH-1:0] w_rd_finish;
    logic                   w_we;
    logic [AW-1:0]          w_waddr;
    logic [DW-1:0]          w_wdata;
    logic [AW-1:0]          w_raddr;

    // Result register.
    logic                   r_ov;
    logic                   r_oconn;
    logic [RES_WIDTH-1:0]   r_obeg;
    logic [RES_WIDTH-1:0]   r_ofin;
    logic                   r_oovf;

    logic                   w_shift;
    logic                   w_ins_done;
    logic                   w_out_free;
    logic                   w_load;
    logic                   w_ev_init;

    assign w_rd_begin  = r_rd[DW-1:COORD_WIDTH];
    assign w_rd_finish = r_rd[COORD_WIDTH-1:0];
    assign w_pos_m1    = r_pos - CNT_W'(1);
    assign w_shift     = (w_rd_begin > r_b);
    assign w_ins_done  = ((r_state == ST_INS_RD) && (r_pos == '0))
                      || ((r_state == ST_INS_CMP) && !w_shift);
    assign w_out_free  = !r_ov || o_out.ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    if (i_ctl.keep) begin
                        n_state = ST_INS_RD;
                    end else if (i_ctl.last) begin
                        n_state = ST_EV_RD;
                    end
                end
            end
            ST_INS_RD: begin
                if (r_pos == '0) begin
                    n_state = r_last ? ST_EV_RD : ST_IDLE;
                end else begin
                    n_state = ST_INS_CMP;
                end
            end
            ST_INS_CMP: begin
                if (w_shift) begin
                    n_state = ST_INS_RD;
                end else begin
                    n_state = r_last ? ST_EV_RD : ST_IDLE;
                end
            end
            ST_EV_RD: begin
                n_state = (r_idx == r_cnt) ? ST_OUT : ST_EV_CMP;
            end
            ST_EV_CMP: begin
                n_state = ST_EV_RD;
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        o_pop   = 1'b0;
        w_we    = 1'b0;
        w_waddr = r_pos[AW-1:0];
        w_wdata = {r_b, r_f};
        w_raddr = r_idx[AW-1:0];
        w_load  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_pop = !i_empty;
            end
            ST_INS_RD: begin
                w_raddr = w_pos_m1[AW-1:0];
                w_we    = (r_pos == '0);
            end
            ST_INS_CMP: begin
                w_we = 1'b1;
                if (w_shift) begin
                    w_wdata = r_rd;
                end
            end
            ST_OUT: begin
                w_load = w_out_free;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    // The walk starts fresh whenever it is entered from idle or from the insertion side.
    assign w_ev_init = (n_state == ST_EV_RD) && (r_state != ST_EV_CMP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Store write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[w_raddr];
    end

    // Latch the popped word; its insertion starts at the end of the store.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b    <= i_begin;
            r_f    <= i_finish;
            r_last <= i_ctl.last;
        end
    end

    // Insertion position walks down while stored starts are greater.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pos <= r_cnt;
        end else if ((r_state == ST_INS_CMP) && w_shift) begin
            r_pos <= w_pos_m1;
        end
    end

    // Fill count and drop mark of the current set.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (w_load) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else begin
            if (w_ins_done) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (o_pop && !i_ctl.keep) begin
                r_ovf <= 1'b1;
            end
        end
    end

    // Running greatest end and gap detection over the ordered store.
    always_ff @(posedge i_clk) begin
        if (w_ev_init) begin
            r_idx  <= '0;
            r_lo   <= '0;
            r_hi   <= '0;
            r_join <= 1'b1;
        end else if (r_state == ST_EV_CMP) begin
            r_idx <= r_idx + CNT_W'(1);
            if (r_idx == '0) begin
                r_lo <= w_rd_begin;
                r_hi <= w_rd_finish;
            end else begin
                if (w_rd_begin > r_hi) begin
                    r_join <= 1'b0;
                end
                if (w_rd_finish > r_hi) begin
                    r_hi <= w_rd_finish;
                end
            end
        end
    end

    // Result word waits here while the back goes on with the next set.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_oconn <= r_join;
            r_obeg  <= r_join ? RES_WIDTH'(r_lo) : '0;
            r_ofin  <= r_join ? RES_WIDTH'(r_hi) : '0;
            r_oovf  <= r_ovf;
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.connected    = r_oconn;
    assign o_out.union_begin  = r_obeg;
    assign o_out.union_finish = r_ofin;
    assign o_out.overflowed   = r_oovf;

endmodule

/* sv/interval_union_span_check_unit.sv */
// Flow: the back pops one word at a time from the queue and inserts it into the ordered store,
// moving each stored interval with a greater start up one place; after a set's marked word,
// kept or dropped, it walks the store and loads the result register once that is free.
// A two-entry queue buffers words, so the front can take words while the back is busy.
// Reset clears the set count, drop mark, queue and result valid; the store is not cleared.
module interval_union_span_check_unit #(
    parameter int unsigned MAX_INTERVALS = ius_pkg::MAX_INTERVALS_DEF,
    parameter int unsigned COORD_WIDTH   = ius_pkg::COORD_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ius_in_if.sink     i_in,
    ius_out_if.source  o_out
);
    import ius_pkg::*;

    localparam int unsigned QW = 2 * COORD_WIDTH + $bits(t_item_ctl);

    logic                   w_push;
    logic                   w_full;
    logic                   w_pop;
    logic                   w_empty;
    logic [COORD_WIDTH-1:0] w_fr_begin;
    logic [COORD_WIDTH-1:0] w_fr_finish;
    t_item_ctl              w_fr_ctl;
    logic [QW-1:0]          w_q_in;
    logic [QW-1:0]          w_q_out;
    logic [COORD_WIDTH-1:0] w_bk_begin;
    logic [COORD_WIDTH-1:0] w_bk_finish;
    t_item_ctl              w_bk_ctl;

    // Front: takes words and marks each as kept or dropped.
    ius_front #(
        .MAX_INTERVALS (MAX_INTERVALS),
        .COORD_WIDTH   (COORD_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_full   (w_full),
        .o_push   (w_push),
        .o_begin  (w_fr_begin),
        .o_finish (w_fr_finish),
        .o_ctl    (w_fr_ctl)
    );

    assign w_q_in = {w_fr_begin, w_fr_finish, w_fr_ctl};

    // Queue between the two halves.
    ius_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_q_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_q_out),
        .o_empty (w_empty)
    );

    assign w_bk_begin  = w_q_out[QW-1 -: COORD_WIDTH];
    assign w_bk_finish = w_q_out[QW-COORD_WIDTH-1 -: COORD_WIDTH];
    assign w_bk_ctl    = w_q_out[$bits(t_item_ctl)-1:0];

    // Back: ordered insertion, span walk and result register.
    ius_back #(
        .MAX_INTERVALS (MAX_INTERVALS),
        .COORD_WIDTH   (COORD_WIDTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_empty),
        .o_pop    (w_pop),
        .i_begin  (w_bk_begin),
        .i_finish (w_bk_finish),
        .i_ctl    (w_bk_ctl),
        .o_out    (o_out)
    );

endmodule

/* sv/ius_checker.sv */
`include "interval_union_span_check_unit_assert.svh"

module ius_checker #(
    parameter int unsigned RW = ius_pkg::RES_WIDTH
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input logic          i_connected,
    input logic [RW-1:0] i_union_begin,
    input logic [RW-1:0] i_union_finish,
    input logic          i_overflowed
);

    // A stalled result word stays up with the same contents.
    `IUS_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_connected) && $stable(i_union_begin) && $stable(i_union_finish) && $stable(i_overflowed))

    // A broken union reports no span.
    `IUS_ASSERT(a_gap_zero, i_clk, i_rst_n, i_out_valid && !i_connected |-> i_union_begin == '0 && i_union_finish == '0)

    // No result word is offered right after a reset cycle.
    `IUS_ASSERT_ANY(a_reset_quiet, i_clk, !i_rst_n |=> !i_out_valid)

endmodule

bind interval_union_span_check_unit ius_checker u_ius_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_connected    (o_out.connected),
    .i_union_begin  (o_out.union_begin),
    .i_union_finish (o_out.union_finish),
    .i_overflowed   (o_out.overflowed)
);
